FILE: sv/bawp_pkg.sv
`default_nettype none

package bawp_pkg;

    localparam int DATA_W  = 32;
    localparam int CORE_W  = 7;
    localparam int INDEX_W = 6;
    localparam int REM_W   = 6;

    // one partition job handed from the front end to the emitter
    typedef struct packed {
        logic [CORE_W-1:0] cores;
        logic [CORE_W-1:0] used;
        logic [CORE_W-1:0] extra;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [REM_W-1:0]  rem;
    } desc_t;

endpackage

`default_nettype wire

FILE: sv/bawp_front.sv
`default_nettype none

module bawp_front
    import bawp_pkg::*;
#(
    parameter int BLOCK_ELEMENTS = 8,
    parameter int MAX_CORES      = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] total_elements,
    input  wire logic [CORE_W-1:0] core_count,
    output logic                   busy,
    output logic                   push_valid,
    output desc_t                  push_desc,
    input  wire logic              push_ready
);

    localparam logic [CORE_W-1:0] BLK  = CORE_W'(BLOCK_ELEMENTS);
    localparam logic [CORE_W-1:0] MAXC = CORE_W'(MAX_CORES);
    localparam int PROD_W = DATA_W + CORE_W;

    // blocks = total / BLOCK_ELEMENTS as (total * RECIP) >> QUO_SH
    localparam int BLK_LOG = $clog2(BLOCK_ELEMENTS);
    localparam int QUO_SH  = DATA_W + BLK_LOG;
    localparam logic [63:0] RECIP =
        ((64'd1 << QUO_SH) + 64'(BLOCK_ELEMENTS) - 64'd1) / 64'(BLOCK_ELEMENTS);
    localparam int HALF_W = 17;
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];
    localparam int PART_W = DATA_W + HALF_W;
    localparam int SUM_W  = PART_W + HALF_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CLASS = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_QUO   = 3'd5;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_FEW  = 2'd1;
    localparam logic [1:0] MODE_EVEN = 2'd2;

    logic [2:0]        state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [1:0]        mode_reg, mode_next;
    logic [DATA_W-1:0] tot_reg, tot_next;
    logic [PART_W-1:0] plo_reg, plo_next;
    logic [PART_W-1:0] phi_reg, phi_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [CORE_W-1:0] r_reg, r_next;
    logic [CORE_W-1:0] cores_reg, cores_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [CORE_W:0]   r_sh;
    logic              ge;
    logic [CORE_W-1:0] r_step;
    logic [DATA_W-1:0] q_step;
    logic [SUM_W-1:0]  prod_w;
    logic [SUM_W-1:0]  quo_w;
    logic [REM_W-1:0]  rem_w;
    logic [PROD_W-1:0] lo_w;
    logic [PROD_W-1:0] hi_w;
    logic [CORE_W-1:0] eff_cores;

    // one restoring divide step per cycle
    always_comb
    begin
        r_sh   = {r_reg, q_reg[DATA_W-1]};
        ge     = r_sh >= {1'b0, cores_reg};
        r_step = ge ? CORE_W'(r_sh - {1'b0, cores_reg}) : r_sh[CORE_W-1:0];
        q_step = {q_reg[DATA_W-2:0], ge};
    end

    // the remainder is below 64, so its low bits are exact
    always_comb
    begin
        prod_w = SUM_W'(plo_reg) + (SUM_W'(phi_reg) << HALF_W);
        quo_w  = prod_w >> QUO_SH;
        rem_w  = tot_reg[REM_W-1:0] - REM_W'(q_reg[REM_W-1:0] * BLK[REM_W-1:0]);
    end

    always_comb
    begin
        if (core_count == '0)
            eff_cores = CORE_W'(1);
        else if (core_count > MAXC)
            eff_cores = MAXC;
        else
            eff_cores = core_count;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        tot_next   = tot_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        cores_next = cores_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    tot_next   = total_elements;
                    cores_next = eff_cores;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                plo_next   = PART_W'(tot_reg) * PART_W'(RECIP_LO);
                phi_next   = PART_W'(tot_reg) * PART_W'(RECIP_HI);
                state_next = ST_QUO;
            end
            ST_QUO:
            begin
                q_next     = quo_w[DATA_W-1:0];
                state_next = ST_CLASS;
            end
            ST_DIV:
            begin
                q_next   = q_step;
                r_next   = r_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_PUSH;
            end
            ST_CLASS:
            begin
                rem_next = rem_w;
                if (q_reg == '0)
                begin
                    mode_next  = MODE_ZERO;
                    state_next = ST_PUSH;
                end
                else if (q_reg <= DATA_W'(cores_reg))
                begin
                    mode_next  = MODE_FEW;
                    state_next = ST_PUSH;
                end
                else
                begin
                    // blocks / cores
                    mode_next  = MODE_EVEN;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lo_w            = PROD_W'(q_reg) * PROD_W'(BLK);
        hi_w            = lo_w + PROD_W'(BLK);
        push_desc.cores = cores_reg;
        push_desc.rem   = rem_reg;
        case (mode_reg)
            MODE_FEW:
            begin
                push_desc.used  = q_reg[CORE_W-1:0];
                push_desc.extra = q_reg[CORE_W-1:0];
                push_desc.lo    = '0;
                push_desc.hi    = DATA_W'(BLK);
            end
            MODE_EVEN:
            begin
                push_desc.used  = cores_reg;
                push_desc.extra = r_reg;
                push_desc.lo    = lo_w[DATA_W-1:0];
                push_desc.hi    = hi_w[DATA_W-1:0];
            end
            default:
            begin
                push_desc.used  = CORE_W'(1);
                push_desc.extra = '0;
                push_desc.lo    = '0;
                push_desc.hi    = '0;
            end
        endcase
    end

    assign push_valid = (state_reg == ST_PUSH);
    assign busy       = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        tot_reg   <= tot_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        cores_reg <= cores_next;
        rem_reg   <= rem_next;
    end

endmodule

`default_nettype wire

FILE: sv/bawp_queue.sv
`default_nettype none

module bawp_queue
    import bawp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       push_ready,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head_desc
);

    desc_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

FILE: sv/bawp_back.sv
`default_nettype none

module bawp_back
    import bawp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire desc_t              head_desc,
    output logic                    pop,
    output logic                    result_valid,
    output logic [INDEX_W-1:0]      core_index,
    output logic [DATA_W-1:0]       start_offset,
    output logic [DATA_W-1:0]       element_count,
    output logic [CORE_W-1:0]       used_cores,
    output logic                    last_core
);

    logic [CORE_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0]  off_reg, off_next;
    logic               valid_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [DATA_W-1:0]  start_reg, start_next;
    logic [DATA_W-1:0]  count_reg, count_next;
    logic [CORE_W-1:0]  used_reg;
    logic               last_reg, last_next;

    logic               in_use;
    logic               last_used;
    logic [DATA_W-1:0]  base;

    always_comb
    begin
        in_use     = idx_reg < head_desc.used;
        last_used  = idx_reg == head_desc.used - CORE_W'(1);
        last_next  = idx_reg == head_desc.cores - CORE_W'(1);
        if (!in_use)
            base = '0;
        else if (idx_reg < head_desc.extra)
            base = head_desc.hi;
        else
            base = head_desc.lo;
        // leftover elements ride on the last used core
        count_next = base + (last_used ? DATA_W'(head_desc.rem) : '0);
        start_next = in_use ? off_reg : '0;
        pop        = head_valid && last_next;
        if (!head_valid)
        begin
            idx_next = idx_reg;
            off_next = off_reg;
        end
        else if (last_next)
        begin
            idx_next = '0;
            off_next = '0;
        end
        else
        begin
            idx_next = idx_reg + CORE_W'(1);
            off_next = off_reg + base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            off_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            off_reg   <= off_next;
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= idx_reg[INDEX_W-1:0];
        start_reg <= start_next;
        count_reg <= count_next;
        used_reg  <= head_desc.used;
        last_reg  <= head_valid && last_next;
    end

    assign result_valid  = valid_reg;
    assign core_index    = index_reg;
    assign start_offset  = start_reg;
    assign element_count = count_reg;
    assign used_cores    = used_reg;
    assign last_core     = last_reg;

endmodule

`default_nettype wire

FILE: sv/block_aligned_work_partitioner_core.sv
// From start the front end steps through its multiply, quotient, classify and push
// states, with a serial divide of the block count by the core count before push when
// there are more blocks than cores. Results then come one per cycle, one per effective
// core. The front end can work on the next job while the emitter emits the last one.
// The receiver cannot stall; results are strobed by result_valid.
// Asynchronous active-low reset idles both halves and sets core_count to 8.
`default_nettype none

module block_aligned_work_partitioner_core
    import bawp_pkg::*;
#(
    parameter int BLOCK_ELEMENTS = 8,
    parameter int MAX_CORES      = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [DATA_W-1:0]  total_elements,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CORE_W-1:0]  cfg_data,
    output logic                    result_valid,
    output logic [INDEX_W-1:0]      core_index,
    output logic [DATA_W-1:0]       start_offset,
    output logic [DATA_W-1:0]       element_count,
    output logic [CORE_W-1:0]       used_cores,
    output logic                    last_core
);

    logic [CORE_W-1:0] core_count_reg;
    logic              push_valid;
    logic              push_ready;
    desc_t             push_desc;
    logic              head_valid;
    desc_t             head_desc;
    logic              pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            core_count_reg <= CORE_W'(8);
        else if (cfg_valid && cfg_ready)
            core_count_reg <= cfg_data;
    end

    bawp_front #(
        .BLOCK_ELEMENTS (BLOCK_ELEMENTS),
        .MAX_CORES      (MAX_CORES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .total_elements (total_elements),
        .core_count     (core_count_reg),
        .busy           (busy),
        .push_valid     (push_valid),
        .push_desc      (push_desc),
        .push_ready     (push_ready)
    );

    bawp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    bawp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_desc     (head_desc),
        .pop           (pop),
        .result_valid  (result_valid),
        .core_index    (core_index),
        .start_offset  (start_offset),
        .element_count (element_count),
        .used_cores    (used_cores),
        .last_core     (last_core)
    );

`ifndef SYNTHESIS
    // cores past the used count carry no work
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (CORE_W'(core_index) >= used_cores)
        |-> (element_count == '0) && (start_offset == '0))
        else $error("unused core reports work");

    // core indexes advance by one within a partition
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (core_index != '0)
        |-> $past(result_valid) && (INDEX_W'($past(core_index) + 1'b1) == core_index))
        else $error("core index sequence broken");

    // a new partition restarts at core zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_core |=> !result_valid || (core_index == '0))
        else $error("partition does not restart at core zero");
`endif

endmodule

`default_nettype wire
